// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AP_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("apu check failed");

// next-cycle implication, off during reset
`define AP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("apu check failed");

// next-cycle implication, always checked
`define AP_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("apu check failed");

`endif

// ===== hdl/afsm_pkg.sv =====
// types, constants and register indexes of the frame sequencer and mixer
// no dependencies
`default_nettype none

package afsm_pkg;

  localparam int TICKS_PER_STEP = 8192;
  localparam int SEQ_STEPS      = 8;
  localparam int DIV_W          = $clog2(TICKS_PER_STEP);
  localparam int STEP_W         = $clog2(SEQ_STEPS);

  localparam logic [STEP_W-1:0] SWEEP_STEP_A = STEP_W'(2);
  localparam logic [STEP_W-1:0] SWEEP_STEP_B = STEP_W'(6);
  localparam logic [STEP_W-1:0] ENV_STEP     = STEP_W'(7);

  localparam int VOL_W      = 4;
  localparam int PHASE_W    = 32;
  localparam int GAIN_W     = 16;
  localparam int MASTER_W   = 3;
  localparam int PAN_W      = 8;
  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 8;
  localparam int SCALE_W    = 13;
  localparam int PROD_W     = 30;
  localparam int GAIN_SHIFT = 8;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] CFG_AUDIO_ENABLE = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_PANNING      = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_MASTER_LEFT  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_MASTER_RIGHT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_STEP  = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_OUTPUT_GAIN  = 3'd5;

  localparam logic [PHASE_W-1:0] SAMPLE_STEP_RESET = 32'd45158;
  localparam logic [GAIN_W-1:0]  OUTPUT_GAIN_RESET = 16'd17476;

  typedef struct packed {
    logic [VOL_W-1:0] vol_ch1;
    logic [VOL_W-1:0] vol_ch2;
    logic [VOL_W-1:0] vol_ch3;
    logic [VOL_W-1:0] vol_ch4;
    logic [3:0]       dac_mask;
  } tick_t;

  typedef struct packed {
    logic                       clock_sweep;
    logic                       clock_length;
    logic                       clock_envelope;
    logic                       sample_valid;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } result_t;

  typedef struct packed {
    logic capture;
    logic scale;
    logic gain;
    logic load;
  } ctl_t;

endpackage

`default_nettype wire

// ===== hdl/apu_frame_sequencer_mixer_top.sv =====
// top level of the sound frame sequencer and stereo mixer
// depends on afsm_pkg, afsm_ctrl and afsm_datapath
`default_nettype none

// One tick beat produces exactly one result beat carrying the sweep, length
// and envelope strobes and, when audio is enabled and the phase accumulator
// carries, a saturated stereo sample. A tick runs through capture (counters,
// phase and channel sums), the master-volume multiply, the gain multiply, and
// the load into the output register, which waits while that register is held.
// The next tick is taken in the cycle after the load, while the result may
// still wait in the output register. Configuration writes are registered.
module apu_frame_sequencer_mixer_top
  import afsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  tick_valid,
  output logic                       tick_stall,
  input  wire tick_t                 tick,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result
);

  ctl_t ctl;
  logic out_free;

  afsm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick_valid),
    .tick_stall (tick_stall),
    .out_free   (out_free),
    .ctl        (ctl)
  );

  afsm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .tick         (tick),
    .ctl          (ctl),
    .out_free     (out_free),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

`default_nettype wire

// ===== hdl/afsm_ctrl.sv =====
// controller: sequences capture, two multiply steps and the output load
// depends on afsm_pkg
`default_nettype none

module afsm_ctrl
  import afsm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic tick_valid,
  output logic      tick_stall,
  input  wire logic out_free,
  output ctl_t      ctl
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCALE = 2'd1;
  localparam logic [1:0] ST_GAIN  = 2'd2;
  localparam logic [1:0] ST_LOAD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next  = state;
    ctl         = '0;
    unique case (state)
      ST_IDLE: begin
        if (tick_valid) begin
          ctl.capture = 1'b1;
          state_next  = ST_SCALE;
        end
      end
      ST_SCALE: begin
        ctl.scale  = 1'b1;
        state_next = ST_GAIN;
      end
      ST_GAIN: begin
        ctl.gain   = 1'b1;
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          ctl.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign tick_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/afsm_datapath.sv =====
// datapath: config registers, sequencer counters, phase accumulator,
// mixer multiplies and the output register; depends on afsm_pkg
`default_nettype none

module afsm_datapath
  import afsm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire tick_t                 tick,
  input  wire ctl_t                  ctl,
  output logic                       out_free,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output result_t                    result
);

  logic                audio_enable;
  logic [PAN_W-1:0]    panning;
  logic [MASTER_W-1:0] master_left;
  logic [MASTER_W-1:0] master_right;
  logic [PHASE_W-1:0]  sample_step;
  logic [GAIN_W-1:0]   output_gain;

  logic [DIV_W-1:0]    seq_divider;
  logic [STEP_W-1:0]   seq_step;
  logic [PHASE_W-1:0]  sample_phase;

  logic                sweep;
  logic                length;
  logic                envelope;
  logic                sample_due;
  logic signed [SUM_W-1:0]   sum_l;
  logic signed [SUM_W-1:0]   sum_r;
  logic signed [SCALE_W-1:0] scale_l;
  logic signed [SCALE_W-1:0] scale_r;
  logic signed [PROD_W-1:0]  prod_l;
  logic signed [PROD_W-1:0]  prod_r;

  logic [DIV_W:0]      div_inc;
  logic                wrap;
  logic [PHASE_W:0]    phase_sum;
  logic [3:0]          factor_l;
  logic [3:0]          factor_r;

  function automatic logic signed [SUM_W-1:0] side_sum(tick_t t, logic [3:0] route);
    logic signed [SUM_W-1:0] acc;
    logic [VOL_W-1:0]        vols [4];
    vols[0] = t.vol_ch1;
    vols[1] = t.vol_ch2;
    vols[2] = t.vol_ch3;
    vols[3] = t.vol_ch4;
    acc = '0;
    for (int n = 0; n < 4; n++) begin
      if (t.dac_mask[n] && route[n]) begin
        acc = acc + (signed'({3'b000, vols[n], 1'b0}) - SUM_W'(15));
      end
    end
    return acc;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] saturate(logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-GAIN_SHIFT-1:0] q;
    q = p[PROD_W-1:GAIN_SHIFT];
    if (q > (PROD_W-GAIN_SHIFT)'(32767)) begin
      return SAMPLE_W'(32767);
    end else if (q < -(PROD_W-GAIN_SHIFT)'(32768)) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return q[SAMPLE_W-1:0];
    end
  endfunction

  assign div_inc   = {1'b0, seq_divider} + (DIV_W+1)'(1);
  assign wrap      = (div_inc == (DIV_W+1)'(TICKS_PER_STEP));
  assign phase_sum = {1'b0, sample_phase} + {1'b0, sample_step};
  assign factor_l  = {1'b0, master_left} + 4'd1;
  assign factor_r  = {1'b0, master_right} + 4'd1;
  assign out_free  = !result_valid || !result_stall;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      audio_enable <= 1'b0;
      panning      <= '0;
      master_left  <= '0;
      master_right <= '0;
      sample_step  <= SAMPLE_STEP_RESET;
      output_gain  <= OUTPUT_GAIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_AUDIO_ENABLE: audio_enable <= cfg_data[0];
        CFG_PANNING:      panning      <= cfg_data[PAN_W-1:0];
        CFG_MASTER_LEFT:  master_left  <= cfg_data[MASTER_W-1:0];
        CFG_MASTER_RIGHT: master_right <= cfg_data[MASTER_W-1:0];
        CFG_SAMPLE_STEP:  sample_step  <= cfg_data[PHASE_W-1:0];
        CFG_OUTPUT_GAIN:  output_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer and phase state
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_divider  <= '0;
      seq_step     <= '0;
      sample_phase <= '0;
    end else if (ctl.capture && audio_enable) begin
      seq_divider  <= wrap ? '0 : div_inc[DIV_W-1:0];
      if (wrap) begin
        seq_step <= seq_step + STEP_W'(1);
      end
      sample_phase <= phase_sum[PHASE_W-1:0];
    end
  end

  // per-tick work registers
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      sweep      <= audio_enable && wrap &&
                    (seq_step == SWEEP_STEP_A || seq_step == SWEEP_STEP_B);
      length     <= audio_enable && wrap && !seq_step[0];
      envelope   <= audio_enable && wrap && (seq_step == ENV_STEP);
      sample_due <= audio_enable && phase_sum[PHASE_W];
      sum_l      <= side_sum(tick, panning[7:4]);
      sum_r      <= side_sum(tick, panning[3:0]);
    end
    if (ctl.scale) begin
      scale_l <= SCALE_W'(sum_l) * SCALE_W'(signed'({1'b0, factor_l}));
      scale_r <= SCALE_W'(sum_r) * SCALE_W'(signed'({1'b0, factor_r}));
    end
    if (ctl.gain) begin
      prod_l <= PROD_W'(scale_l) * PROD_W'(signed'({1'b0, output_gain}));
      prod_r <= PROD_W'(scale_r) * PROD_W'(signed'({1'b0, output_gain}));
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ctl.load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      result.clock_sweep    <= sweep;
      result.clock_length   <= length;
      result.clock_envelope <= envelope;
      result.sample_valid   <= sample_due;
      result.sample_left    <= sample_due ? saturate(prod_l) : '0;
      result.sample_right   <= sample_due ? saturate(prod_r) : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/afsm_checker.sv =====
// port-level checks of the frame sequencer and mixer, bound to the top level
// depends on afsm_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module afsm_checker
  import afsm_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst,
  input wire logic    tick_valid,
  input wire logic    tick_stall,
  input wire logic    result_valid,
  input wire logic    result_stall,
  input wire result_t result
);

  // held result beat
  `AP_ASSERT_NEXT(a_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))

  // one tick at a time
  `AP_ASSERT_NEXT(a_one_tick, clk, rst, tick_valid && !tick_stall, tick_stall)

  // no sample means silent outputs
  `AP_ASSERT_IMP(a_silent, clk, rst, result_valid && !result.sample_valid, result.sample_left == 16'sd0 && result.sample_right == 16'sd0)

  // sweep falls on an even step, envelope on an odd one
  `AP_ASSERT_IMP(a_strobes, clk, rst, result_valid && result.clock_sweep, result.clock_length && !result.clock_envelope)

  // reset empties the output register
  `AP_ASSERT_NEXT_ALWAYS(a_reset, clk, rst, !result_valid)

endmodule

bind apu_frame_sequencer_mixer_top afsm_checker u_afsm_checker (
  .clk          (clk),
  .rst          (rst),
  .tick_valid   (tick_valid),
  .tick_stall   (tick_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);

`default_nettype wire
